FILE: rtl/fgpa_pkg.sv
// ----------------------------------------------------------------------------
// fgpa_pkg: shared types and constants for the film grain pixel apply unit
// Template geometry, hash constants, rounding constants, register indexes.
// ----------------------------------------------------------------------------
package fgpa_pkg;

   // template geometry
   localparam int TPL_SIDE_W  = 6;
   localparam int TPL_SIDE    = 1 << TPL_SIDE_W;
   localparam int TPL_ADDR_W  = 2 * TPL_SIDE_W;
   localparam int TPL_AREA    = 1 << TPL_ADDR_W;
   localparam int TPL_PLANES  = 3;
   localparam int TPL_VAL_W   = 9;
   localparam int BLK_W       = 5;          // 32x32 grain blocks

   // hash constants
   localparam logic [31:0] MIX_SEED  = 32'h9E3779B1;
   localparam logic [31:0] MIX_COL   = 32'h85EBCA77;
   localparam logic [31:0] MIX_ROW   = 32'hC2B2AE3D;
   localparam logic [31:0] MIX_FINAL = 32'h2C1B3C6D;
   // (plane + 1) * 0x27D4EB2F, modulo 2^32
   localparam logic [31:0] PLANE_KEY [TPL_PLANES] = '{32'h27D4EB2F, 32'h4FA9D65E,
                                                       32'h777EC18D};

   // strength interpolation
   localparam int          STEP_Y      = 17;
   localparam int          STR_W       = 13;  // 255 * 17 fits
   localparam logic [15:0] DIV17_Y_MUL = 16'd241;  // y / 17 = (y * 241) >> 12
   localparam int          DIV17_Y_SH  = 12;

   // rounding division: d = 2^sh * 17, quotient = floor(((|n| + d/2) >> sh) / 17)
   localparam int          LUMA_SH     = 9;    // 64 * 8
   localparam int          CHROMA_SH   = 14;   // 64 * 8 * 32
   localparam logic [31:0] LUMA_HALF   = 32'((64 * 8 * 17) / 2);
   localparam logic [31:0] CHROMA_HALF = 32'((64 * 8 * 17 * 32) / 2);
   localparam logic [31:0] DIV17_MUL   = 32'd61681;  // ceil(2^20 / 17)
   localparam int          DIV17_SH    = 20;
   localparam int          QUOT_W      = 12;

   localparam int PIPE_STAGES = 10;
   localparam int MEM_STAGE   = 4;

   typedef enum logic [2:0] {
      CSR_GRAIN_SEED     = 3'd0,
      CSR_CHROMA_B_GAIN  = 3'd1,
      CSR_CHROMA_R_GAIN  = 3'd2,
      CSR_STRENGTH_LOW   = 3'd3,
      CSR_STRENGTH_HIGH  = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      PLANE_Y  = 2'd0,
      PLANE_CB = 2'd1,
      PLANE_CR = 2'd2,
      PLANE_NONE = 2'd3
   } plane_type;

   typedef struct packed {
      logic [1:0]                  plane;
      logic [TPL_ADDR_W-1:0]       addr;
      logic signed [TPL_VAL_W-1:0] value;
   } load_type;

   typedef struct packed {
      logic [7:0] cr;
      logic [7:0] cb;
      logic [7:0] luma;
   } sample_type;

endpackage

FILE: rtl/film_grain_pixel_apply_unit.sv
// ----------------------------------------------------------------------------
// film_grain_pixel_apply_unit: adds synthetic film grain to YCbCr pixels
//
// Usage:
//   req_* carries one item per transfer. req_tuser = 0 loads one word of a
//   grain template (luma, Cb or Cr), req_tuser = 1 processes one pixel.
//   Each pixel transfer yields exactly one rsp_* transfer, in order; load
//   transfers yield none.
//   csr_* writes a configuration register; the user must do so only while the
//   unit is idle, as the unit does not enforce it. Throughput is one item per
//   cycle while rsp_tready is high: the unit is a ten-stage pipeline with a
//   valid bit per stage, and the template memories are read and written in
//   stage four, so a load is seen by every pixel behind it.
//   When rsp_tready is low, the output stage holds and bubbles ahead of it
//   fill up; req_tready drops only when all ten stages hold items.
//   Reset (synchronous, active high) empties the pipeline and restores the
//   register defaults (seed 1, gains 32, strength points 0). Template
//   contents are not cleared and must be loaded before pixels use them.
// ----------------------------------------------------------------------------
module film_grain_pixel_apply_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] action: 0 load template word, 1 pixel
   // [1:0] template_plane, [13:2] template_address, [22:14] template_value,
   // [36:23] pixel_col, [50:37] pixel_row, [58:51] luma_in, [66:59] cb_in,
   // [74:67] cr_in, [79:75] zero
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] luma_out, [15:8] cb_out, [23:16] cr_out
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   localparam int NS = fgpa_pkg::PIPE_STAGES;
   localparam int AW = fgpa_pkg::TPL_ADDR_W;
   localparam int NP = fgpa_pkg::TPL_PLANES;

   // ---------------- configuration registers ----------------
   logic [15:0]  seed_ff;
   logic [7:0]   gain_b_ff;
   logic [7:0]   gain_r_ff;
   logic [127:0] points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= 16'd1;
         gain_b_ff <= 8'd32;
         gain_r_ff <= 8'd32;
         points_ff <= '0;
      end else if (csr_we) begin
         case (fgpa_pkg::csr_idx_type'(csr_addr))
            fgpa_pkg::CSR_GRAIN_SEED:    seed_ff <= csr_wdata[15:0];
            fgpa_pkg::CSR_CHROMA_B_GAIN: gain_b_ff <= csr_wdata[7:0];
            fgpa_pkg::CSR_CHROMA_R_GAIN: gain_r_ff <= csr_wdata[7:0];
            fgpa_pkg::CSR_STRENGTH_LOW:  points_ff[63:0] <= csr_wdata;
            fgpa_pkg::CSR_STRENGTH_HIGH: points_ff[127:64] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] en;
   logic [3:0]    pix_ff;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = req_tvalid;
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
      // loads retire in the memory stage
      vld_in[fgpa_pkg::MEM_STAGE] = vld_ff[fgpa_pkg::MEM_STAGE-1] && pix_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_tready = en[0];

   // ---------------- payload carried along ----------------
   fgpa_pkg::sample_type smp_ff [NS];
   fgpa_pkg::load_type   ld_ff [4];
   logic [13:0]          col0_ff, row0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pix_ff[0]     <= req_tuser;
         ld_ff[0]      <= '{plane: req_tdata[1:0], addr: AW'(req_tdata[13:2]),
                            value: req_tdata[22:14]};
         col0_ff       <= req_tdata[36:23];
         row0_ff       <= req_tdata[50:37];
         smp_ff[0]     <= '{cr: req_tdata[74:67], cb: req_tdata[66:59],
                            luma: req_tdata[58:51]};
      end
      for (int k = 1; k < 4; k++) begin
         if (en[k]) begin
            pix_ff[k] <= pix_ff[k-1];
            ld_ff[k]  <= ld_ff[k-1];
         end
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            smp_ff[k] <= smp_ff[k-1];
         end
      end
   end

   // ---------------- stage 1: hash base, strength ----------------
   logic [31:0]               hb_in, hb1_ff;
   logic [fgpa_pkg::BLK_W-1:0] colb1_ff, rowb1_ff, colb2_ff, rowb2_ff;
   logic [15:0]               seg_prod;
   logic [3:0]                seg, nxt;
   logic [4:0]                frac;
   logic [7:0]                pt_a, pt_b;
   logic [fgpa_pkg::STR_W-1:0] str_in;
   logic [fgpa_pkg::STR_W-1:0] str_ff [1:4];

   always_comb begin
      hb_in = 32'({16'd0, seed_ff} * fgpa_pkg::MIX_SEED)
            ^ 32'({23'd0, col0_ff[13:5]} * fgpa_pkg::MIX_COL)
            ^ 32'({23'd0, row0_ff[13:5]} * fgpa_pkg::MIX_ROW);
      seg_prod = 16'({8'd0, smp_ff[0].luma} * fgpa_pkg::DIV17_Y_MUL);
      seg      = seg_prod[15:12];
      frac     = 5'(smp_ff[0].luma - 8'(seg * 8'(fgpa_pkg::STEP_Y)));
      nxt      = (seg == 4'd15) ? 4'd15 : seg + 4'd1;
      pt_a     = points_ff[{seg, 3'b000} +: 8];
      pt_b     = points_ff[{nxt, 3'b000} +: 8];
      str_in   = fgpa_pkg::STR_W'(pt_a * (5'(fgpa_pkg::STEP_Y) - frac))
               + fgpa_pkg::STR_W'(pt_b * frac);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hb1_ff   <= hb_in;
         colb1_ff <= col0_ff[fgpa_pkg::BLK_W-1:0];
         rowb1_ff <= row0_ff[fgpa_pkg::BLK_W-1:0];
         str_ff[1] <= str_in;
      end
      for (int k = 2; k <= 4; k++) begin
         if (en[k]) begin
            str_ff[k] <= str_ff[k-1];
         end
      end
   end

   // ---------------- stage 2: per-plane finalizing multiply ----------------
   logic [31:0] mh_in [NP];
   logic [31:0] mh2_ff [NP];

   always_comb begin
      logic [31:0] g;
      for (int p = 0; p < NP; p++) begin
         g = hb1_ff ^ fgpa_pkg::PLANE_KEY[p];
         g = g ^ (g >> 15);
         mh_in[p] = 32'(g * fgpa_pkg::MIX_FINAL);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mh2_ff   <= mh_in;
         colb2_ff <= colb1_ff;
         rowb2_ff <= rowb1_ff;
      end
   end

   // ---------------- stage 3: template read addresses ----------------
   logic [AW-1:0] idx_in [NP];
   logic [AW-1:0] idx3_ff [NP];

   always_comb begin
      logic [31:0] h;
      logic [5:0]  r, c;
      for (int p = 0; p < NP; p++) begin
         h = mh2_ff[p] ^ (mh2_ff[p] >> 12);
         r = {1'b0, h[9:5]} + {1'b0, rowb2_ff};
         c = {1'b0, h[4:0]} + {1'b0, colb2_ff};
         idx_in[p] = AW'((32'(r) << fgpa_pkg::TPL_SIDE_W) + 32'(c));
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         idx3_ff <= idx_in;
      end
   end

   // ---------------- stage 4: template memories ----------------
   logic signed [fgpa_pkg::TPL_VAL_W-1:0] tpl4_ff [NP];
   logic                                  wr_go;

   assign wr_go = en[fgpa_pkg::MEM_STAGE] && vld_ff[3] && !pix_ff[3];

   for (genvar p = 0; p < NP; p++) begin : g_tpl
      logic signed [fgpa_pkg::TPL_VAL_W-1:0] mem [fgpa_pkg::TPL_AREA];

      always_ff @(posedge clock) begin
         if (wr_go && ld_ff[3].plane == 2'(p)) begin
            mem[ld_ff[3].addr] <= ld_ff[3].value;
         end
         if (en[fgpa_pkg::MEM_STAGE]) begin
            tpl4_ff[p] <= mem[idx3_ff[p]];
         end
      end
   end

   // ---------------- stage 5: template times strength ----------------
   logic signed [21:0] prod5_ff [NP];

   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int p = 0; p < NP; p++) begin
            prod5_ff[p] <= 22'(tpl4_ff[p]) * 22'($signed({1'b0, str_ff[4]}));
         end
      end
   end

   // ---------------- stage 6: chroma gains ----------------
   logic signed [30:0] n6_ff [NP];

   always_ff @(posedge clock) begin
      if (en[6]) begin
         n6_ff[fgpa_pkg::PLANE_Y]  <= 31'(prod5_ff[fgpa_pkg::PLANE_Y]);
         n6_ff[fgpa_pkg::PLANE_CB] <= 31'(prod5_ff[fgpa_pkg::PLANE_CB])
                                    * 31'($signed({1'b0, gain_b_ff}));
         n6_ff[fgpa_pkg::PLANE_CR] <= 31'(prod5_ff[fgpa_pkg::PLANE_CR])
                                    * 31'($signed({1'b0, gain_r_ff}));
      end
   end

   // ---------------- stage 7: magnitude, round, power-of-two part ----------------
   logic [15:0]   x_in [NP];
   logic [15:0]   x7_ff [NP];
   logic [NP-1:0] neg_in, neg7_ff, neg8_ff;

   always_comb begin
      logic [31:0] nx, mag;
      for (int p = 0; p < NP; p++) begin
         nx        = 32'(n6_ff[p]);
         neg_in[p] = nx[31];
         mag       = nx[31] ? 32'(-nx) : nx;
         if (p == fgpa_pkg::PLANE_Y) begin
            x_in[p] = 16'((mag + fgpa_pkg::LUMA_HALF) >> fgpa_pkg::LUMA_SH);
         end else begin
            x_in[p] = 16'((mag + fgpa_pkg::CHROMA_HALF) >> fgpa_pkg::CHROMA_SH);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         x7_ff   <= x_in;
         neg7_ff <= neg_in;
      end
   end

   // ---------------- stage 8: divide by 17 ----------------
   logic [fgpa_pkg::QUOT_W-1:0] q8_ff [NP];

   always_ff @(posedge clock) begin
      if (en[8]) begin
         for (int p = 0; p < NP; p++) begin
            q8_ff[p] <= fgpa_pkg::QUOT_W'((32'(x7_ff[p]) * fgpa_pkg::DIV17_MUL)
                                          >> fgpa_pkg::DIV17_SH);
         end
         neg8_ff <= neg7_ff;
      end
   end

   // ---------------- stage 9: add grain, clamp ----------------
   logic [7:0] smp8 [NP];
   logic [7:0] out_in [NP];
   logic [7:0] out9_ff [NP];

   always_comb begin
      logic signed [13:0] sum;
      smp8[fgpa_pkg::PLANE_Y]  = smp_ff[8].luma;
      smp8[fgpa_pkg::PLANE_CB] = smp_ff[8].cb;
      smp8[fgpa_pkg::PLANE_CR] = smp_ff[8].cr;
      for (int p = 0; p < NP; p++) begin
         if (neg8_ff[p]) begin
            sum = $signed({6'd0, smp8[p]}) - $signed({2'b00, q8_ff[p]});
         end else begin
            sum = $signed({6'd0, smp8[p]}) + $signed({2'b00, q8_ff[p]});
         end
         if (sum < 0) begin
            out_in[p] = 8'd0;
         end else if (sum > 14'sd255) begin
            out_in[p] = 8'd255;
         end else begin
            out_in[p] = sum[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         out9_ff <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {out9_ff[fgpa_pkg::PLANE_CR], out9_ff[fgpa_pkg::PLANE_CB],
                        out9_ff[fgpa_pkg::PLANE_Y]};

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for film_grain_pixel_apply_unit
// Fills all three grain templates, walks a short directed table (first with
// reset settings, then with every gain and strength point at full scale),
// then runs random pixel/load traffic over several register settings. Every
// pixel is predicted in the bench and compared in order against rsp_*.
// ----------------------------------------------------------------------------
module tb_top;
   import fgpa_pkg::*;

   localparam int          PIPE_LAT    = 10;
   localparam int          HOLD_CYCLES = 80;
   localparam int          STEP_Y_TB   = 17;
   localparam int          N_POINTS    = 16;
   localparam int          TPL_W       = 64;
   localparam int          TPL_CELLS   = TPL_W * TPL_W;
   localparam longint      LUMA_DIV    = 64 * 8 * 17;
   localparam longint      CHROMA_DIV  = 64 * 8 * 17 * 32;
   localparam logic [31:0] SEED_MUL    = 32'h9E3779B1;
   localparam logic [31:0] COL_MUL     = 32'h85EBCA77;
   localparam logic [31:0] ROW_MUL     = 32'hC2B2AE3D;
   localparam logic [31:0] PLANE_MUL   = 32'h27D4EB2F;
   localparam logic [31:0] FINAL_MUL   = 32'h2C1B3C6D;
   localparam logic [2:0]  CSR_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  CSR_SPARE_LAST  = 3'd7;
   localparam logic        ACT_LOAD  = 1'b0;
   localparam logic        ACT_PIXEL = 1'b1;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = 1'b0;
   logic [79:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [63:0] csr_wdata  = '0;

   // predictor state
   logic [8:0]  grain_tpl [3][TPL_CELLS];
   logic [15:0] seed_r    = 16'd1;
   logic [7:0]  gain_cb   = 8'd32;
   logic [7:0]  gain_cr   = 8'd32;
   logic [63:0] points_lo = '0;
   logic [63:0] points_hi = '0;

   sample_type  expected_pixels [$];
   int          fail_cnt     = 0;
   bit          send_calm    = 1'b0;
   bit          recv_calm    = 1'b0;
   bit          hold_off_req = 1'b0;

   typedef struct packed {
      logic       act;
      logic [1:0] plane;
      logic [11:0] addr;
      logic [8:0] value;
      logic [13:0] col;
      logic [13:0] row;
      logic [7:0] y;
      logic [7:0] cb;
      logic [7:0] cr;
      sample_type want;   // only meaningful with reset settings (no grain)
   } grain_row_t;

   grain_row_t dir_tab [12] = '{
      '{ACT_LOAD,  PLANE_Y,    12'd0,    9'h100, 14'd0,     14'd0,     8'd0,   8'd0,
         8'd0,   '{8'd0,   8'd0,   8'd0}},
      '{ACT_LOAD,  PLANE_CB,   12'd4095, 9'h0FF, 14'd0,     14'd0,     8'd0,   8'd0,
         8'd0,   '{8'd0,   8'd0,   8'd0}},
      '{ACT_LOAD,  PLANE_CR,   12'd2047, 9'h101, 14'd0,     14'd0,     8'd0,   8'd0,
         8'd0,   '{8'd0,   8'd0,   8'd0}},
      '{ACT_LOAD,  PLANE_NONE, 12'd12,   9'h064, 14'd0,     14'd0,     8'd0,   8'd0,
         8'd0,   '{8'd0,   8'd0,   8'd0}},
      '{ACT_PIXEL, PLANE_Y,    12'd0,    9'h000, 14'd0,     14'd0,     8'd0,   8'd0,
         8'd0,   '{8'd0,   8'd0,   8'd0}},
      '{ACT_PIXEL, PLANE_Y,    12'd0,    9'h000, 14'd16383, 14'd16383, 8'd255, 8'd255,
         8'd255, '{8'd255, 8'd255, 8'd255}},
      '{ACT_PIXEL, PLANE_Y,    12'd0,    9'h000, 14'd31,    14'd31,    8'd254, 8'd0,
         8'd255, '{8'd255, 8'd0,   8'd254}},
      '{ACT_PIXEL, PLANE_Y,    12'd0,    9'h000, 14'd32,    14'd32,    8'd17,  8'd128,
         8'd128, '{8'd128, 8'd128, 8'd17}},
      '{ACT_PIXEL, PLANE_Y,    12'd0,    9'h000, 14'd16383, 14'd0,     8'd16,  8'd255,
         8'd0,   '{8'd0,   8'd255, 8'd16}},
      '{ACT_LOAD,  PLANE_Y,    12'd4030, 9'h001, 14'd0,     14'd0,     8'd0,   8'd0,
         8'd0,   '{8'd0,   8'd0,   8'd0}},
      '{ACT_PIXEL, PLANE_Y,    12'd0,    9'h000, 14'd63,    14'd16383, 8'd255, 8'd1,
         8'd254, '{8'd254, 8'd1,   8'd255}},
      '{ACT_PIXEL, PLANE_Y,    12'd0,    9'h000, 14'd8192,  14'd95,    8'd34,  8'd85,
         8'd170, '{8'd170, 8'd85,  8'd34}}
   };

   film_grain_pixel_apply_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic logic [79:0] pack_req(input logic [1:0] plane, input logic [11:0] addr,
                                            input logic [8:0] value, input logic [13:0] col,
                                            input logic [13:0] row, input logic [7:0] y,
                                            input logic [7:0] cb, input logic [7:0] cr);
      return {5'b0, cr, cb, y, row, col, value, addr, plane};
   endfunction

   function automatic logic [31:0] block_hash(input logic [15:0] seed, input logic [8:0] bcol,
                                              input logic [8:0] brow, input int plane);
      logic [31:0] h;
      h = (32'(seed) * SEED_MUL) ^ (32'(bcol) * COL_MUL) ^ (32'(brow) * ROW_MUL) ^
          (32'(plane + 1) * PLANE_MUL);
      h = h ^ (h >> 15);
      h = h * FINAL_MUL;
      h = h ^ (h >> 12);
      return h;
   endfunction

   function automatic longint grain_tap(input int plane, input logic [13:0] col,
                                        input logic [13:0] row);
      logic [31:0] h;
      int r, c;
      h = block_hash(seed_r, col[13:5], row[13:5], plane);
      r = h[9:5] + row[4:0];
      c = h[4:0] + col[4:0];
      return longint'($signed(grain_tpl[plane][(r * TPL_W + c) % TPL_CELLS]));
   endfunction

   function automatic longint strength_point(input longint k);
      return (k < 8) ? longint'(points_lo[k*8 +: 8]) : longint'(points_hi[(k-8)*8 +: 8]);
   endfunction

   function automatic longint round_div(input longint n, input longint dv);
      return (n >= 0) ? (n + dv / 2) / dv : -((-n + dv / 2) / dv);
   endfunction

   function automatic logic [7:0] sat8(input longint v);
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic sample_type grain_pixel(input logic [79:0] d);
      logic [13:0] col, row;
      longint y, cb, cr, seg, frac, nxt, s;
      sample_type px;
      col  = d[36:23];
      row  = d[50:37];
      y    = d[58:51];
      cb   = d[66:59];
      cr   = d[74:67];
      seg  = y / STEP_Y_TB;
      frac = y - seg * STEP_Y_TB;
      // Y = 255 lands on the last point; it interpolates toward itself
      nxt  = (seg + 1 < N_POINTS) ? seg + 1 : N_POINTS - 1;
      s    = strength_point(seg) * (STEP_Y_TB - frac) + strength_point(nxt) * frac;
      px.luma = sat8(y + round_div(grain_tap(0, col, row) * s, LUMA_DIV));
      px.cb   = sat8(cb + round_div(grain_tap(1, col, row) * s * longint'(gain_cb),
                                    CHROMA_DIV));
      px.cr   = sat8(cr + round_div(grain_tap(2, col, row) * s * longint'(gain_cr),
                                    CHROMA_DIV));
      return px;
   endfunction

   // update the templates or queue the predicted pixel for an accepted item
   task automatic take_item(input logic act, input logic [79:0] d);
      if (act == ACT_PIXEL)
         expected_pixels.push_back(grain_pixel(d));
      else if (d[1:0] != PLANE_NONE)
         grain_tpl[d[1:0]][d[13:2]] = d[22:14];
   endtask

   // ---------------------------------------------------------------- drivers
   // called at a rising edge; returns at the edge of the transfer
   task automatic put_item(input logic act, input logic [79:0] d);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= d;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_GRAIN_SEED:    seed_r    = val[15:0];
         CSR_CHROMA_B_GAIN: gain_cb   = val[7:0];
         CSR_CHROMA_R_GAIN: gain_cr   = val[7:0];
         CSR_STRENGTH_LOW:  points_lo = val;
         CSR_STRENGTH_HIGH: points_hi = val;
         default: ;
      endcase
   endtask

   task automatic set_grain_config(input logic [63:0] seed, input logic [63:0] gb,
                                   input logic [63:0] gr, input logic [63:0] lo,
                                   input logic [63:0] hi);
      write_reg(CSR_GRAIN_SEED, seed);
      write_reg(CSR_CHROMA_B_GAIN, gb);
      write_reg(CSR_CHROMA_R_GAIN, gr);
      write_reg(CSR_STRENGTH_LOW, lo);
      write_reg(CSR_STRENGTH_HIGH, hi);
      // unmapped index, must not disturb anything
      write_reg(3'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), {$urandom, $urandom});
   endtask

   // loads give no response, so give the pipe its latency after the last pixel
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic run_table(input bit typed);
      grain_row_t r;
      logic [79:0] d;
      for (int i = 0; i < $size(dir_tab); i++) begin
         r = dir_tab[i];
         d = pack_req(r.plane, r.addr, r.value, r.col, r.row, r.y, r.cb, r.cr);
         put_item(r.act, d);
         if (typed && r.act == ACT_PIXEL)
            expected_pixels.push_back(r.want);
         else
            take_item(r.act, d);
      end
   endtask

   task automatic run_random(input int n_items);
      logic        act;
      logic [79:0] d;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
         act = ($urandom_range(0, 3) != 0) ? ACT_PIXEL : ACT_LOAD;
         d   = {5'b0, 11'($urandom_range(0, 2047)), $urandom, $urandom};
         if ($urandom_range(0, 7) == 0) d[58:51] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         if ($urandom_range(0, 7) == 0) d[66:59] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         if ($urandom_range(0, 7) == 0) d[74:67] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         put_item(act, d);
         take_item(act, d);
      end
   endtask

   // ---------------------------------------------------------------- checking
   task automatic check_pixel(input sample_type got);
      sample_type want;
      if (expected_pixels.size() == 0) begin
         fail_cnt++;
         if (fail_cnt <= 10)
            $display("%0t: pixel out with none pending: y=%0d cb=%0d cr=%0d",
                     $realtime, got.luma, got.cb, got.cr);
      end else begin
         want = expected_pixels.pop_front();
         if (got.luma !== want.luma || got.cb !== want.cb || got.cr !== want.cr) begin
            fail_cnt++;
            if (fail_cnt <= 10)
               $display("%0t: pixel mismatch: exp y=%0d cb=%0d cr=%0d, got y=%0d cb=%0d cr=%0d",
                        $realtime, want.luma, want.cb, want.cr, got.luma, got.cb, got.cr);
         end
      end
   endtask

   // handshake sampled mid-cycle; the transfer lands on the following rising edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_pixel(rsp_tdata);
   end

   initial begin : rsp_sink
      int gap;
      int seen;
      seen = 0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (seen % 40 == 0) recv_calm = ($urandom_range(0, 2) == 0);
         gap = recv_calm ? 0 : $urandom_range(0, 5);
         if (hold_off_req) begin
            // long back-pressure: pipe fills and req_tready drops
            hold_off_req = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
         seen++;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin : stim
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every template word written once so no pixel reads an empty cell
      send_calm = 1'b1;
      for (int p = 0; p < 3; p++) begin
         for (int a = 0; a < TPL_CELLS; a++) begin
            logic [79:0] d;
            d = pack_req(2'(p), 12'(a), 9'($urandom), 14'($urandom), 14'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
            put_item(ACT_LOAD, d);
            take_item(ACT_LOAD, d);
         end
      end

      // reset settings: strength points are zero, pixels pass unchanged
      send_calm = 1'b0;
      run_table(1'b1);
      wait_idle();
      set_grain_config('1, '1, '1, '1, '1);
      run_table(1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            0: set_grain_config('0, '0, '0, {$urandom, $urandom}, {$urandom, $urandom});
            1: begin
               set_grain_config({$urandom, $urandom}, 64'd32, 64'd32,
                                {$urandom, $urandom}, {$urandom, $urandom});
               hold_off_req = 1'b1;
            end
            2: set_grain_config({$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, '0, '1);
            4: begin
               set_grain_config('1, '1, '1, '1, '1);
               hold_off_req = 1'b1;
            end
            default: set_grain_config({$urandom, $urandom}, {$urandom, $urandom},
                                      {$urandom, $urandom}, {$urandom, $urandom},
                                      {$urandom, $urandom});
         endcase
         run_random(320);
      end
      wait_idle();

      if (fail_cnt == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
